// File: sv/imhdk_pkg.sv
// Package: sequencer states, operation and status codes, key and node-count constants for the indexed min-heap.
package imhdk_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FILL,
      ST_DK_POS,
      ST_DK_HEAP,
      ST_UP,
      ST_EX_RD,
      ST_DN,
      ST_RESP
   } state_type;

   localparam logic [1:0] OP_RESTART  = 2'd0;
   localparam logic [1:0] OP_DECREASE = 2'd1;
   localparam logic [1:0] OP_EXTRACT  = 2'd2;

   localparam logic [1:0] STATUS_DONE    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY   = 2'd1;
   localparam logic [1:0] STATUS_IGNORED = 2'd2;

   localparam logic [63:0] KEY_ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [10:0] NODE_COUNT_RST = 11'd1024;

endpackage

// File: sv/indexed_min_heap_decrease_key.sv
// Indexed binary min-heap with decrease-key: sequencer around heap and position memories.
// One request is handled at a time and gives one response. Restart writes one heap entry a
// cycle, together with its position, for min(node_count, NODES) entries. Decrease lets the
// key climb level by level; extract moves the last entry to the root and lets it sink level
// by level. Each sift step reads parent or both children (two read ports) and writes back
// one entry and one position in the same cycle. The response sits in an output register, so
// the next request is taken while it waits. The configuration port is always ready.
module indexed_min_heap_decrease_key
   import imhdk_pkg::*;
#(
   parameter int NODES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // node[9:0], new_key[73:10], zero pad
   input  logic [1:0]  req_tuser,   // operation[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // min_node[9:0], min_key[73:10], zero pad
   output logic [1:0]  rsp_tuser,   // status[1:0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [10:0] csr_wdata    // node_count
);

   localparam int PW = $clog2(NODES);
   localparam int CW = $clog2(NODES + 1);

   typedef struct packed {
      logic [PW-1:0] id;
      logic [63:0]   key;
   } entry_type;

   entry_type     heap_mem [NODES];
   logic [PW-1:0] pos_mem  [NODES];

   state_type     state_ff, state_in;
   logic [PW-1:0] p_ff, p_in;
   entry_type     x_ff, x_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [10:0]   ncfg_ff;
   logic [9:0]    node_ff, node_in;
   logic [63:0]   key_ff, key_in;
   logic [1:0]    res_status_ff, res_status_in;
   logic [9:0]    res_node_ff, res_node_in;
   logic [63:0]   res_key_ff, res_key_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [79:0]   rsp_data_ff, rsp_data_in;
   logic [1:0]    rsp_user_ff, rsp_user_in;

   entry_type     rd_a_ff, rd_b_ff;
   logic [PW-1:0] pos_rd_ff;

   logic          heap_we;
   logic [PW-1:0] heap_wa;
   entry_type     heap_wd;
   logic          pos_we;
   logic [PW-1:0] pos_wa;
   logic [PW-1:0] pos_wd;
   logic [PW-1:0] ra, rb, pa;

   logic [1:0]    req_op;
   logic [9:0]    req_node;
   logic [CW-1:0] fill_n;
   logic [PW-1:0] par, par2;
   logic [CW:0]   lft, rgt, blft, brgt;
   logic          lv, rv;
   logic [1:0]    best_sel;
   logic [63:0]   best_key;
   logic [PW-1:0] best_pos;
   entry_type     child;

   assign req_op   = req_tuser;
   assign req_node = req_tdata[9:0];
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   assign fill_n = ({21'd0, ncfg_ff} > 32'(NODES)) ? CW'(NODES) : CW'(ncfg_ff);

   assign par  = PW'((p_ff - PW'(1)) >> 1);
   assign par2 = PW'((par - PW'(1)) >> 1);

   assign lft = (CW + 1)'({1'b0, p_ff, 1'b1});
   assign rgt = lft + (CW + 1)'(1);
   assign lv  = lft < {1'b0, count_ff};
   assign rv  = rgt < {1'b0, count_ff};

   always_comb begin
      best_sel = 2'd0;
      best_key = x_ff.key;
      if (lv && rd_a_ff.key < best_key) begin
         best_sel = 2'd1;
         best_key = rd_a_ff.key;
      end
      if (rv && rd_b_ff.key < best_key) begin
         best_sel = 2'd2;
      end
   end

   assign child    = (best_sel == 2'd2) ? rd_b_ff : rd_a_ff;
   assign best_pos = (best_sel == 2'd2) ? PW'(rgt) : PW'(lft);
   assign blft     = (CW + 1)'({1'b0, best_pos, 1'b1});
   assign brgt     = blft + (CW + 1)'(1);

   always_comb begin
      state_in      = state_ff;
      p_in          = p_ff;
      x_in          = x_ff;
      count_in      = count_ff;
      fill_in       = fill_ff;
      node_in       = node_ff;
      key_in        = key_ff;
      res_status_in = res_status_ff;
      res_node_in   = res_node_ff;
      res_key_in    = res_key_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;
      heap_we       = 1'b0;
      heap_wa       = p_ff;
      heap_wd       = x_ff;
      pos_we        = 1'b0;
      pos_wa        = x_ff.id;
      pos_wd        = p_ff;
      ra            = '0;
      rb            = '0;
      pa            = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               node_in       = req_node;
               key_in        = req_tdata[73:10];
               res_status_in = STATUS_DONE;
               res_node_in   = '0;
               res_key_in    = '0;
               case (req_op)
                  OP_RESTART: begin
                     fill_in  = '0;
                     state_in = ST_FILL;
                  end
                  OP_DECREASE: begin
                     if ({22'd0, req_node} < 32'(NODES)) begin
                        pa       = PW'(req_node);
                        state_in = ST_DK_POS;
                     end else begin
                        res_status_in = STATUS_IGNORED;
                        state_in      = ST_RESP;
                     end
                  end
                  OP_EXTRACT: begin
                     if (count_ff == '0) begin
                        res_status_in = STATUS_EMPTY;
                        state_in      = ST_RESP;
                     end else begin
                        ra       = '0;
                        rb       = PW'(count_ff - CW'(1));
                        state_in = ST_EX_RD;
                     end
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end
         ST_FILL: begin
            if (fill_ff < fill_n) begin
               heap_we     = 1'b1;
               heap_wa     = PW'(fill_ff);
               heap_wd.id  = PW'(fill_ff);
               heap_wd.key = KEY_ALL_ONES;
               pos_we      = 1'b1;
               pos_wa      = PW'(fill_ff);
               pos_wd      = PW'(fill_ff);
               fill_in     = fill_ff + CW'(1);
            end else begin
               count_in = fill_n;
               state_in = ST_RESP;
            end
         end
         ST_DK_POS: begin
            if ({1'b0, pos_rd_ff} < (PW + 1)'(count_ff)) begin
               ra       = pos_rd_ff;
               p_in     = pos_rd_ff;
               state_in = ST_DK_HEAP;
            end else begin
               res_status_in = STATUS_IGNORED;
               state_in      = ST_RESP;
            end
         end
         ST_DK_HEAP: begin
            if (rd_a_ff.id == PW'(node_ff) && key_ff < rd_a_ff.key) begin
               x_in.id  = PW'(node_ff);
               x_in.key = key_ff;
               ra       = par;
               state_in = ST_UP;
            end else begin
               res_status_in = STATUS_IGNORED;
               state_in      = ST_RESP;
            end
         end
         ST_UP: begin
            heap_we = 1'b1;
            pos_we  = 1'b1;
            if (p_ff != '0 && x_ff.key < rd_a_ff.key) begin
               heap_wd = rd_a_ff;
               pos_wa  = rd_a_ff.id;
               p_in    = par;
               ra      = par2;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_EX_RD: begin
            res_node_in = 10'(rd_a_ff.id);
            res_key_in  = rd_a_ff.key;
            pos_we      = 1'b1;
            pos_wa      = rd_a_ff.id;
            pos_wd      = PW'(count_ff - CW'(1));
            count_in    = count_ff - CW'(1);
            x_in        = rd_b_ff;
            p_in        = '0;
            ra          = PW'(1);
            rb          = PW'(2);
            state_in    = ST_DN;
         end
         ST_DN: begin
            heap_we = 1'b1;
            pos_we  = 1'b1;
            if (best_sel != 2'd0) begin
               heap_wd = child;
               pos_wa  = child.id;
               p_in    = best_pos;
               ra      = PW'(blft);
               rb      = PW'(brgt);
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {6'd0, res_key_ff, res_node_ff};
               rsp_user_in  = res_status_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (heap_we) begin
         heap_mem[heap_wa] <= heap_wd;
      end
      rd_a_ff <= heap_mem[ra];
      rd_b_ff <= heap_mem[rb];
   end

   always_ff @(posedge clock) begin
      if (pos_we) begin
         pos_mem[pos_wa] <= pos_wd;
      end
      pos_rd_ff <= pos_mem[pa];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ncfg_ff      <= NODE_COUNT_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            ncfg_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      p_ff          <= p_in;
      x_ff          <= x_in;
      fill_ff       <= fill_in;
      node_ff       <= node_in;
      key_ff        <= key_in;
      res_status_ff <= res_status_in;
      res_node_ff   <= res_node_in;
      res_key_ff    <= res_key_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_user_ff   <= rsp_user_in;
   end

endmodule
